// ===== rtl/tcw_pkg.sv =====
// Shared constants and controller/datapath interface types for the text console writer.
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int CELL_W   = 16;
	localparam int CHAR_W   = 8;
	localparam int COLOR_W  = 4;
	localparam int OPCODE_W = 2;
	localparam int ADDR_W   = 11;
	localparam int CFG_IDX_W = 1;

	localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'b1;

	localparam logic [COLOR_W-1:0] FG_RESET = 4'h7;
	localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_LAST  = 8'hFF;

	localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

	typedef struct packed {
		logic accept;
		logic put;
		logic read;
		logic clear;
		logic fill;
		logic fill_init;
		logic scroll;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic scroll_need;
		logic scroll_end;
		logic fill_end;
		logic out_valid;
	} stat_t;

endpackage

// ===== rtl/tcw_ctrl.sv =====
// Sequencing state machine for the text console writer.
module tcw_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tcw_pkg::OPCODE_W-1:0]    opcode,
	input  logic                            out_ready,
	input  tcw_pkg::stat_t                  stat,
	output tcw_pkg::cmd_t                   cmd
);

	typedef enum logic [5:0] {
		ST_INIT   = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_CLEAR  = 6'b000100,
		ST_SCROLL = 6'b001000,
		ST_FILL   = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.fill      = 1'b1;
				cmd.fill_init = 1'b1;
				if (stat.fill_end) state_n = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (opcode)
						tcw_pkg::OP_PUT: begin
							cmd.put = 1'b1;
							state_n = stat.scroll_need ? ST_SCROLL : ST_EMIT;
						end
						tcw_pkg::OP_READ: begin
							cmd.read = 1'b1;
							state_n  = ST_EMIT;
						end
						tcw_pkg::OP_CLEAR: begin
							cmd.clear = 1'b1;
							state_n   = ST_CLEAR;
						end
						default: state_n = ST_EMIT;
					endcase
				end
			end
			ST_CLEAR: begin
				cmd.fill = 1'b1;
				if (stat.fill_end) state_n = ST_EMIT;
			end
			ST_SCROLL: begin
				cmd.scroll = 1'b1;
				// the counter runs on into the blank last row
				if (stat.scroll_end) state_n = ST_FILL;
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (stat.fill_end) state_n = ST_EMIT;
			end
			ST_EMIT: begin
				// hold until the output register is free
				if (!stat.out_valid || out_ready) begin
					cmd.emit = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: state_n = ST_INIT;
		endcase
	end

endmodule

// ===== rtl/tcw_datapath.sv =====
// Cursor, attribute registers, screen memory, sweep counter and output register.
module tcw_datapath #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tcw_pkg::cmd_t                    cmd,
	output tcw_pkg::stat_t                   stat,
	input  logic                             cfg_write,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tcw_pkg::COLOR_W-1:0]      cfg_data,
	input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
	input  logic [tcw_pkg::ADDR_W-1:0]       cell_address,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [tcw_pkg::CELL_W-1:0]       cell_value,
	output logic [tcw_pkg::ADDR_W-1:0]       cursor_index
);

	localparam int CELLS    = COLUMNS * ROWS;
	localparam int AW       = $clog2(CELLS);
	localparam int COLW     = $clog2(COLUMNS);
	localparam int ROWW     = $clog2(ROWS);
	localparam int CW       = $clog2(COLUMNS + 4);
	localparam int RW       = $clog2(ROWS + 1);
	localparam int SCROLL_N = (ROWS - 1) * COLUMNS;
	localparam int IW       = tcw_pkg::ADDR_W;
	localparam int DW       = tcw_pkg::CELL_W;

	logic [tcw_pkg::COLOR_W-1:0] fg_q, bg_q;
	logic [COLW-1:0]             col_q;
	logic [ROWW-1:0]             row_q;
	logic [AW-1:0]               sweep_q;
	logic                        read_ok_q;
	logic                        out_valid_q;
	logic [DW-1:0]               cell_value_q;
	logic [IW-1:0]               cursor_index_q;
	logic [DW-1:0]               rdata_q;
	logic [DW-1:0]               mem [CELLS];

	logic [CW-1:0] col_w;
	logic [RW-1:0] row_w;
	logic          wr_char;
	logic          scroll_need;
	logic          in_range;
	logic [AW-1:0] pos;
	logic [DW-1:0] blank;
	logic          we, re;
	logic [AW-1:0] wa, ra;
	logic [DW-1:0] wd;

	assign blank    = {bg_q, fg_q, tcw_pkg::CH_SPACE};
	assign pos      = AW'(32'(row_q) * COLUMNS + 32'(col_q));
	assign in_range = 32'(cell_address) < 32'(CELLS);

	// next cursor for a put character
	always_comb begin
		col_w   = CW'(col_q);
		row_w   = RW'(row_q);
		wr_char = 1'b0;
		case (char_code) inside
			tcw_pkg::CH_BS: begin
				if (col_q != '0) col_w = CW'(col_q) - CW'(1);
				else if (row_q != '0) row_w = RW'(row_q) - RW'(1);
			end
			tcw_pkg::CH_TAB: col_w = (CW'(col_q) + CW'(4)) & ~CW'(3);
			tcw_pkg::CH_CR:  col_w = '0;
			tcw_pkg::CH_LF: begin
				col_w = '0;
				row_w = RW'(row_q) + RW'(1);
			end
			[tcw_pkg::CH_SPACE:tcw_pkg::CH_LAST]: begin
				wr_char = 1'b1;
				col_w   = CW'(col_q) + CW'(1);
			end
			default: ;
		endcase
		if (col_w >= CW'(COLUMNS)) begin
			col_w = '0;
			row_w = row_w + RW'(1);
		end
	end

	assign scroll_need = row_w == RW'(ROWS);

	// memory port selection
	always_comb begin
		we = 1'b0;
		wa = pos;
		wd = {bg_q, fg_q, char_code};
		re = 1'b0;
		ra = AW'(cell_address);
		if (cmd.put && wr_char) begin
			we = 1'b1;
		end
		if (cmd.fill) begin
			we = 1'b1;
			wa = sweep_q;
			wd = cmd.fill_init ? tcw_pkg::RESET_CELL : blank;
		end
		if (cmd.scroll) begin
			// read one row below, write the word read last cycle one row up
			we = sweep_q != '0;
			wa = sweep_q - AW'(1);
			wd = rdata_q;
			re = sweep_q != AW'(SCROLL_N);
			ra = AW'(32'(sweep_q) + COLUMNS);
		end
		if (cmd.read) begin
			re = in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rdata_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q        <= tcw_pkg::FG_RESET;
			bg_q        <= tcw_pkg::BG_RESET;
			col_q       <= '0;
			row_q       <= '0;
			sweep_q     <= '0;
			read_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write && cfg_index == tcw_pkg::REG_FOREGROUND) fg_q <= cfg_data;
			if (cfg_write && cfg_index == tcw_pkg::REG_BACKGROUND) bg_q <= cfg_data;
			if (cmd.accept) read_ok_q <= cmd.read && in_range;
			if (cmd.put) begin
				col_q <= COLW'(col_w);
				row_q <= scroll_need ? ROWW'(ROWS - 1) : ROWW'(row_w);
			end
			if (cmd.clear) begin
				col_q <= '0;
				row_q <= '0;
			end
			if (cmd.clear || cmd.put) begin
				sweep_q <= '0;
			end else if (cmd.fill || (cmd.scroll && sweep_q != AW'(SCROLL_N))) begin
				// hold on the first cell of the last row for the blanking pass
				sweep_q <= sweep_q + AW'(1);
			end
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			cell_value_q   <= read_ok_q ? rdata_q : '0;
			cursor_index_q <= IW'(32'(row_q) * COLUMNS + 32'(col_q));
		end
	end

	assign stat.scroll_need = scroll_need;
	assign stat.scroll_end  = sweep_q == AW'(SCROLL_N);
	assign stat.fill_end    = sweep_q == AW'(CELLS - 1);
	assign stat.out_valid   = out_valid_q;

	assign out_valid    = out_valid_q;
	assign cell_value   = cell_value_q;
	assign cursor_index = cursor_index_q;

	a_no_emit_over_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit && out_valid_q && !out_ready))
		else $error("result loaded over an unsent result");

	a_cursor_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |=> (32'(col_q) < COLUMNS) && (32'(row_q) < ROWS))
		else $error("cursor left the screen");

	a_clear_homes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> col_q == '0 && row_q == '0 && sweep_q == '0)
		else $error("clear did not home the cursor");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> 32'(cursor_index_q) < 32'(CELLS))
		else $error("reported cursor index out of range");

	a_sweep_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.put, cmd.read, cmd.fill, cmd.scroll, cmd.emit}) <= 1)
		else $error("conflicting datapath commands");

endmodule

// ===== rtl/text_console_writer_unit.sv =====
// Text console writer: cursor handling, screen buffer, scroll and clear.
//
// Items arrive on the in_valid/in_ready channel (opcode, char_code, cell_address);
// every item yields exactly one transaction on out_valid/out_ready
// (cell_value, cursor_index). foreground and background are set through the
// cfg_write/cfg_index/cfg_data port and take effect at once.
//
// Per item, put character, read cell and unused opcodes go straight from the
// accepting state to loading the result; the screen memory takes at most one
// write or one read per such item. A line feed or wrap past the last row first
// scrolls rows 1 to ROWS-1 up by one row and then blanks the last row. Clear
// blanks all COLUMNS*ROWS cells and homes the cursor.
// One item is in work at a time; in_ready is high only between items.
//
// After reset the screen memory is swept to grey-on-black blanks, one cell a
// cycle, over all COLUMNS*ROWS cells with in_ready low.
// If the receiver stalls, the finished result is held in the output register;
// one more item may be accepted and worked, and then waits until it drains.
module text_console_writer_unit #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tcw_pkg::COLOR_W-1:0]      cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [tcw_pkg::OPCODE_W-1:0]     opcode,
	input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
	input  logic [tcw_pkg::ADDR_W-1:0]       cell_address,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tcw_pkg::CELL_W-1:0]       cell_value,
	output logic [tcw_pkg::ADDR_W-1:0]       cursor_index
);

	tcw_pkg::cmd_t  cmd;
	tcw_pkg::stat_t stat;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tcw_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.char_code    (char_code),
		.cell_address (cell_address),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.cell_value   (cell_value),
		.cursor_index (cursor_index)
	);

endmodule
